[rtl/core/assert_macros.svh]
// Assertion macros used by the frame timing selector controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AFTS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define AFTS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define AFTS_ASSERT(label, clk, rst_n, prop)
`define AFTS_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/afts_pkg.sv]
// Shared widths, codes and defaults of the animation frame timing selector.
package afts_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int NUM_W   = 16;
    localparam int DUR_W   = 20;
    localparam int ACC_W   = 32;
    localparam int ENTRY_W = NUM_W + DUR_W;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

endpackage

[rtl/core/afts_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface afts_item_if;
    import afts_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [NUM_W-1:0] frame_number;
    logic             number_missing;
    logic [DUR_W-1:0] frame_duration;
    logic [DUR_W-1:0] tick_delta;

    modport source (
        output valid, kind, frame_number, number_missing, frame_duration, tick_delta,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_number, number_missing, frame_duration, tick_delta,
        output ready
    );
endinterface

interface afts_result_if;
    import afts_pkg::*;

    logic             valid;
    logic             ready;
    logic             frame_stored;
    logic             table_full;
    logic             frame_changed;
    logic             shown_valid;
    logic [NUM_W-1:0] shown_frame;

    modport source (
        output valid, frame_stored, table_full, frame_changed, shown_valid, shown_frame,
        input  ready
    );
    modport sink (
        input  valid, frame_stored, table_full, frame_changed, shown_valid, shown_frame,
        output ready
    );
endinterface

[rtl/core/afts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module afts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/afts_ctrl.sv]
// Sequencer that scans the frame table and keeps timing and selection state.
`include "assert_macros.svh"

module afts_ctrl #(
    parameter int MAX_FRAMES = afts_pkg::MAX_FRAMES_DEF,
    parameter int AW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    afts_item_if.sink                req,
    afts_result_if.source            rsp,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic [afts_pkg::ENTRY_W-1:0] rd_data,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [afts_pkg::ENTRY_W-1:0] wr_data
);
    import afts_pkg::*;

    localparam int CW = $clog2(MAX_FRAMES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PADD  = 3'd1;
    localparam logic [2:0] ST_PWRAP = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [ACC_W-1:0] total_reg, total_next;
    logic [ACC_W-1:0] progress_reg, progress_next;
    logic [NUM_W-1:0] cur_frame_reg, cur_frame_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [CW-1:0]    iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic [ACC_W-1:0] sum_reg, sum_next;
    logic             res_stored_reg, res_stored_next;
    logic             res_full_reg, res_full_next;
    logic             res_changed_reg, res_changed_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_stored_reg, out_stored_next;
    logic             out_full_reg, out_full_next;
    logic             out_changed_reg, out_changed_next;
    logic             out_shown_valid_reg, out_shown_valid_next;
    logic [NUM_W-1:0] out_shown_frame_reg, out_shown_frame_next;

    // Captured item payload.
    logic             kind_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DUR_W-1:0] dur_reg;
    logic [DUR_W-1:0] delta_reg;

    logic             accept;
    logic             issue;
    logic             match;
    logic [NUM_W-1:0] rd_num;
    logic [DUR_W-1:0] rd_dur;
    logic [ACC_W-1:0] sum_acc;

    assign accept  = req.valid && req.ready;
    assign rd_num  = rd_data[ENTRY_W-1 -: NUM_W];
    assign rd_dur  = rd_data[DUR_W-1:0];
    assign sum_acc = sum_reg + ACC_W'(rd_dur);
    assign issue   = iss_reg < count_reg;
    assign match   = (kind_reg == KIND_ADD) ? (rd_num == num_reg) : (sum_acc >= progress_reg);

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.frame_stored  = out_stored_reg;
    assign rsp.table_full    = out_full_reg;
    assign rsp.frame_changed = out_changed_reg;
    assign rsp.shown_valid   = out_shown_valid_reg;
    assign rsp.shown_frame   = out_shown_frame_reg;

    assign rd_addr = iss_reg[AW-1:0];
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = {num_reg, dur_reg};

    always_comb
    begin
        state_next           = state_reg;
        count_next           = count_reg;
        total_next           = total_reg;
        progress_next        = progress_reg;
        cur_frame_next       = cur_frame_reg;
        cur_valid_next       = cur_valid_reg;
        iss_next             = iss_reg;
        pend_next            = pend_reg;
        sum_next             = sum_reg;
        res_stored_next      = res_stored_reg;
        res_full_next        = res_full_reg;
        res_changed_next     = res_changed_reg;
        out_valid_next       = out_valid_reg && !rsp.ready;
        out_stored_next      = out_stored_reg;
        out_full_next        = out_full_reg;
        out_changed_next     = out_changed_reg;
        out_shown_valid_next = out_shown_valid_reg;
        out_shown_frame_next = out_shown_frame_reg;
        rd_en                = 1'b0;
        wr_en                = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    iss_next         = '0;
                    pend_next        = 1'b0;
                    sum_next         = '0;
                    res_stored_next  = 1'b0;
                    res_full_next    = 1'b0;
                    res_changed_next = 1'b0;
                    if (req.kind == KIND_TICK)
                    begin
                        state_next = ST_PADD;
                    end
                    else if (req.number_missing)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_PADD:
            begin
                progress_next = progress_reg + ACC_W'(delta_reg);
                state_next    = ST_PWRAP;
            end
            ST_PWRAP:
            begin
                if (progress_reg > total_reg)
                begin
                    progress_next = progress_reg - total_reg;
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Reads are issued one entry a cycle; the entry read in the
                // previous cycle is examined while the next one is fetched.
                if (pend_reg && kind_reg == KIND_TICK)
                begin
                    sum_next = sum_acc;
                end
                if (pend_reg && match)
                begin
                    pend_next = 1'b0;
                    if (kind_reg == KIND_TICK)
                    begin
                        res_changed_next = !cur_valid_reg || (rd_num != cur_frame_reg);
                        cur_frame_next   = rd_num;
                        cur_valid_next   = 1'b1;
                    end
                    state_next = ST_HOLD;
                end
                else if (!pend_reg && !issue)
                begin
                    // The whole table was walked without a hit.
                    if (kind_reg == KIND_ADD)
                    begin
                        if (count_reg < CW'(MAX_FRAMES))
                        begin
                            wr_en           = 1'b1;
                            count_next      = count_reg + 1'b1;
                            total_next      = total_reg + ACC_W'(dur_reg);
                            res_stored_next = 1'b1;
                        end
                        else
                        begin
                            res_full_next = 1'b1;
                        end
                    end
                    state_next = ST_HOLD;
                end
                else
                begin
                    rd_en     = issue;
                    pend_next = issue;
                    if (issue)
                    begin
                        iss_next = iss_reg + 1'b1;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_stored_next      = res_stored_reg;
                    out_full_next        = res_full_reg;
                    out_changed_next     = res_changed_reg;
                    out_shown_valid_next = cur_valid_reg;
                    out_shown_frame_next = cur_valid_reg ? cur_frame_reg : '0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            count_reg           <= '0;
            total_reg           <= '0;
            progress_reg        <= '0;
            cur_frame_reg       <= '0;
            cur_valid_reg       <= 1'b0;
            iss_reg             <= '0;
            pend_reg            <= 1'b0;
            sum_reg             <= '0;
            res_stored_reg      <= 1'b0;
            res_full_reg        <= 1'b0;
            res_changed_reg     <= 1'b0;
            out_valid_reg       <= 1'b0;
            out_stored_reg      <= 1'b0;
            out_full_reg        <= 1'b0;
            out_changed_reg     <= 1'b0;
            out_shown_valid_reg <= 1'b0;
            out_shown_frame_reg <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            count_reg           <= count_next;
            total_reg           <= total_next;
            progress_reg        <= progress_next;
            cur_frame_reg       <= cur_frame_next;
            cur_valid_reg       <= cur_valid_next;
            iss_reg             <= iss_next;
            pend_reg            <= pend_next;
            sum_reg             <= sum_next;
            res_stored_reg      <= res_stored_next;
            res_full_reg        <= res_full_next;
            res_changed_reg     <= res_changed_next;
            out_valid_reg       <= out_valid_next;
            out_stored_reg      <= out_stored_next;
            out_full_reg        <= out_full_next;
            out_changed_reg     <= out_changed_next;
            out_shown_valid_reg <= out_shown_valid_next;
            out_shown_frame_reg <= out_shown_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.kind;
            num_reg   <= req.frame_number;
            dur_reg   <= req.frame_duration;
            delta_reg <= req.tick_delta;
        end
    end

    `AFTS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_FRAMES))
    `AFTS_ASSERT(a_write_grows, clk, rst_n, wr_en |=> count_reg == $past(count_reg) + 1'b1)
    `AFTS_ASSERT(a_read_in_range, clk, rst_n, rd_en |-> iss_reg < count_reg)
    `AFTS_NEVER(a_flags_exclusive, clk, rst_n, out_valid_reg && out_stored_reg && out_full_reg)
    `AFTS_ASSERT(a_change_shows, clk, rst_n, out_valid_reg && out_changed_reg |-> out_shown_valid_reg)

endmodule

[rtl/core/animation_frame_timing_selector.sv]
// Top level of the animation frame timing selector.
// The frame table (number and duration of each frame) sits in one RAM with a single read port,
// and an item walks the stored entries one per cycle: an add item looks for a duplicate number
// before it appends, a tick item first advances and wraps the progress, then accumulates durations
// until the running sum reaches it. An add item whose number is missing skips the walk. The block
// takes one item at a time, and the result is held in an output register until the downstream
// side takes it.
module animation_frame_timing_selector #(
    parameter int MAX_FRAMES = afts_pkg::MAX_FRAMES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    afts_item_if.sink     req,
    afts_result_if.source rsp
);
    import afts_pkg::*;

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    afts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    afts_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .AW         (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

[bench/testbench.sv]
// Self-checking testbench for the animation frame timing selector.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import afts_pkg::*;

    localparam int MAX_FRAMES   = MAX_FRAMES_DEF;
    localparam int DRAIN_CYCLES = MAX_FRAMES + 16;

    typedef struct packed {
        logic             kind;
        logic [NUM_W-1:0] frame_number;
        logic             number_missing;
        logic [DUR_W-1:0] frame_duration;
        logic [DUR_W-1:0] tick_delta;
    } frame_item_t;

    typedef struct packed {
        logic             frame_stored;
        logic             table_full;
        logic             frame_changed;
        logic             shown_valid;
        logic [NUM_W-1:0] shown_frame;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    afts_item_if   req_if();
    afts_result_if rsp_if();

    animation_frame_timing_selector i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Own copy of the frame table and the playback state.
    bit [NUM_W-1:0] kept_number   [MAX_FRAMES];
    bit [DUR_W-1:0] kept_duration [MAX_FRAMES];
    int unsigned    kept_count;
    bit [ACC_W-1:0] total_time;
    bit [ACC_W-1:0] play_time;
    bit [NUM_W-1:0] on_screen;
    bit             on_screen_valid;

    outcome_t    pending_outcomes[$];
    int unsigned mismatches;
    int unsigned add_count, tick_count, stored_count, full_count, change_count;
    bit          calm;

    function automatic bit is_kept(input bit [NUM_W-1:0] num);
        int unsigned idx;
        for (idx = 0; idx < kept_count; idx++)
            if (kept_number[idx] == num)
                return 1'b1;
        return 1'b0;
    endfunction

    // Applies one item to the playback state and returns the result it must produce.
    function automatic outcome_t play_item(input frame_item_t it);
        outcome_t       res;
        bit [ACC_W-1:0] run_sum;
        int unsigned    idx;
        bit             found;
        res     = '0;
        run_sum = '0;
        found   = 1'b0;
        if (it.kind == KIND_ADD)
        begin
            add_count++;
            if (!it.number_missing && !is_kept(it.frame_number))
            begin
                if (kept_count < MAX_FRAMES)
                begin
                    kept_number[kept_count]   = it.frame_number;
                    kept_duration[kept_count] = it.frame_duration;
                    kept_count++;
                    total_time += ACC_W'(it.frame_duration);
                    res.frame_stored = 1'b1;
                    stored_count++;
                end
                else
                begin
                    res.table_full = 1'b1;
                    full_count++;
                end
            end
        end
        else
        begin
            tick_count++;
            play_time += ACC_W'(it.tick_delta);
            if (play_time > total_time)
                play_time -= total_time;
            for (idx = 0; idx < kept_count && !found; idx++)
            begin
                run_sum += ACC_W'(kept_duration[idx]);
                if (run_sum >= play_time)
                begin
                    found = 1'b1;
                    if (!on_screen_valid || kept_number[idx] != on_screen)
                    begin
                        res.frame_changed = 1'b1;
                        change_count++;
                    end
                    on_screen       = kept_number[idx];
                    on_screen_valid = 1'b1;
                end
            end
        end
        res.shown_valid = on_screen_valid;
        res.shown_frame = on_screen_valid ? on_screen : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Holds one item on the request channel until the block takes it.
    task automatic send_item(input frame_item_t it);
        if (!calm && $urandom_range(99) < 33)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.kind           <= it.kind;
        req_if.frame_number   <= it.frame_number;
        req_if.number_missing <= it.number_missing;
        req_if.frame_duration <= it.frame_duration;
        req_if.tick_delta     <= it.tick_delta;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_outcomes.insert(pending_outcomes.size(), play_item(it));
    endtask

    task automatic add_frame(input bit [NUM_W-1:0] num, input bit [DUR_W-1:0] dur,
                             input bit missing);
        frame_item_t it;
        it                = '0;
        it.kind           = KIND_ADD;
        it.frame_number   = num;
        it.number_missing = missing;
        it.frame_duration = dur;
        it.tick_delta     = DUR_W'($urandom_range(0, 20'hFFFFF));
        send_item(it);
    endtask

    task automatic tick(input bit [DUR_W-1:0] delta);
        frame_item_t it;
        it                = '0;
        it.kind           = KIND_TICK;
        it.frame_number   = NUM_W'($urandom_range(0, 16'hFFFF));
        it.number_missing = 1'($urandom_range(0, 1));
        it.frame_duration = DUR_W'($urandom_range(0, 20'hFFFFF));
        it.tick_delta     = delta;
        send_item(it);
    endtask

    // Result side: stall at random unless in a calm stretch.
    always @(posedge clk)
        rsp_if.ready <= rst_n && (calm || $urandom_range(99) >= 33);

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result arrived with no item pending");
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_if.frame_stored !== want.frame_stored)
                    report_mismatch($sformatf("frame_stored got %b expected %b",
                                              rsp_if.frame_stored, want.frame_stored));
                if (rsp_if.table_full !== want.table_full)
                    report_mismatch($sformatf("table_full got %b expected %b",
                                              rsp_if.table_full, want.table_full));
                if (rsp_if.frame_changed !== want.frame_changed)
                    report_mismatch($sformatf("frame_changed got %b expected %b",
                                              rsp_if.frame_changed, want.frame_changed));
                if (rsp_if.shown_valid !== want.shown_valid)
                    report_mismatch($sformatf("shown_valid got %b expected %b",
                                              rsp_if.shown_valid, want.shown_valid));
                if (rsp_if.shown_frame !== want.shown_frame)
                    report_mismatch($sformatf("shown_frame got %h expected %h",
                                              rsp_if.shown_frame, want.shown_frame));
            end
        end
    end

    task automatic test_empty_table();
        tick(20'h00000);
        tick(20'hFFFFF);
        add_frame(16'hFFFF, 20'hFFFFF, 1'b1);
        tick(20'h00001);
    endtask

    // With no frames the total stays zero, so full-size ticks only push the
    // progress up and never select a frame.
    task automatic test_progress_climb();
        calm = 1'b1;
        repeat (4) tick(20'hFFFFF);
        calm = 1'b0;
    endtask

    task automatic test_directed_frames();
        add_frame(16'h0000, 20'h00000, 1'b0);
        add_frame(16'hFFFF, 20'hFFFFF, 1'b0);
        add_frame(16'hFFFF, 20'h00005, 1'b0);
        add_frame(16'h1234, 20'h00003, 1'b1);
        add_frame(16'h0000, 20'h00007, 1'b1);
        tick(20'h00000);
        tick(20'h00001);
        add_frame(16'hAAAA, 20'h55555, 1'b0);
        add_frame(16'h5555, 20'hAAAAA, 1'b0);
        tick(20'h55555);
        tick(20'hAAAAA);
        tick(20'hFFFFF);
        tick(20'hFFFFF);
        add_frame(16'h0001, 20'h00001, 1'b0);
        add_frame(16'h8000, 20'h80000, 1'b0);
        tick(20'h00000);
        tick(20'h00001);
        tick(20'hFFFFF);
        tick(20'h7FFFF);
    endtask

    task automatic test_random_play(input int unsigned n_items, input int unsigned calm_from);
        int unsigned    k, pick;
        bit [ACC_W-1:0] span;
        bit [DUR_W-1:0] dur, delta;
        for (k = 0; k < n_items; k++)
        begin
            calm = (k >= calm_from) && (k < calm_from + 150);
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // Durations lean small so that a walk crosses many entries.
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: dur = DUR_W'($urandom_range(0, 64));
                    5, 6, 7:       dur = DUR_W'($urandom_range(0, 4095));
                    default:       dur = DUR_W'($urandom_range(0, 20'hFFFFF));
                endcase
                add_frame(NUM_W'($urandom_range(0, 16'hFFFF)), dur, 1'b0);
            end
            else if (pick < 10)
            begin
                if (pick % 2 == 0 && kept_count != 0)
                    add_frame(kept_number[$urandom_range(kept_count - 1)],
                              DUR_W'($urandom_range(0, 20'hFFFFF)), 1'b0);
                else
                    add_frame(NUM_W'($urandom_range(0, 16'hFFFF)),
                              DUR_W'($urandom_range(0, 20'hFFFFF)), 1'b1);
            end
            else
            begin
                span = total_time / 4 + 1;
                case ($urandom_range(9))
                    7, 8:    delta = DUR_W'($urandom_range(0, 16));
                    9:       delta = DUR_W'($urandom_range(0, 20'hFFFFF));
                    default: delta = (span > 20'hFFFFF) ? DUR_W'($urandom_range(0, 20'hFFFFF))
                                                        : DUR_W'($urandom_range(0, span));
                endcase
                tick(delta);
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_table_full();
        bit [NUM_W-1:0] num;
        while (kept_count < MAX_FRAMES)
        begin
            num = NUM_W'($urandom_range(0, 16'hFFFF));
            if (!is_kept(num))
                add_frame(num, DUR_W'($urandom_range(0, 255)), 1'b0);
        end
        do
            num = NUM_W'($urandom_range(0, 16'hFFFF));
        while (is_kept(num));
        add_frame(num, 20'hFFFFF, 1'b0);
        // A duplicate or a missing number is ignored before the room check.
        add_frame(kept_number[MAX_FRAMES - 1], 20'h00000, 1'b0);
        add_frame(num, 20'h00005, 1'b1);
        add_frame(~num, 20'h00000, 1'b0);
        tick(20'h00003);
    endtask

    initial
    begin
        #30_000_000;
        $display("animation_frame_timing_selector test failed");
        $finish;
    end

    initial
    begin
        int unsigned wait_cycles;
        rst_n                 = 1'b0;
        calm                  = 1'b0;
        req_if.valid          = 1'b0;
        req_if.kind           = KIND_ADD;
        req_if.frame_number   = '0;
        req_if.number_missing = 1'b0;
        req_if.frame_duration = '0;
        req_if.tick_delta     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_progress_climb();
        test_directed_frames();
        test_random_play(1200, 400);
        test_table_full();
        test_random_play(500, 1000);

        req_if.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_outcomes.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));

        $display("Sent %0d adds and %0d ticks: %0d frames stored, %0d dropped on a full table,",
                 add_count, tick_count, stored_count, full_count);
        $display("%0d changes of the shown frame, with ticks on an empty and on a full table.",
                 change_count);
        if (mismatches == 0)
            $display("animation_frame_timing_selector test passed");
        else
            $display("animation_frame_timing_selector test failed");
        $finish;
    end

endmodule
